[src/lkvc_pkg.sv]
// lkvc_pkg: shared constants for the lru key/value cache
// operation codes and the capacity register width; no dependencies

package lkvc_pkg;

    // width of the capacity configuration register
    localparam int CAP_WIDTH = 5;

    // operation codes carried on func
    localparam logic FUNC_GET = 1'b0;
    localparam logic FUNC_SET = 1'b1;

endpackage : lkvc_pkg

[src/lkvc_cell.sv]
// lkvc_cell: one entry of the recency-ordered cache chain
// holds valid, key and value; loads from its more recent neighbor on shift

module lkvc_cell #(
    parameter int KEY_WIDTH   = 16,
    parameter int VALUE_WIDTH = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   shift_en,
    input  logic                   prev_valid,
    input  logic [KEY_WIDTH-1:0]   prev_key,
    input  logic [VALUE_WIDTH-1:0] prev_value,
    input  logic [KEY_WIDTH-1:0]   lookup_key,
    output logic                   valid,
    output logic [KEY_WIDTH-1:0]   key,
    output logic [VALUE_WIDTH-1:0] value,
    output logic                   match
);

    logic                   valid_reg;
    logic [KEY_WIDTH-1:0]   key_reg;
    logic [VALUE_WIDTH-1:0] value_reg;

    // valid bit, cleared at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (shift_en)
        begin
            valid_reg <= prev_valid;
        end
    end

    // entry payload
    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            key_reg   <= prev_key;
            value_reg <= prev_value;
        end
    end

    // local key compare
    assign match = valid_reg && (key_reg == lookup_key);
    assign valid = valid_reg;
    assign key   = key_reg;
    assign value = value_reg;

endmodule : lkvc_cell

[src/lru_key_value_cache_top.sv]
// lru_key_value_cache_top: fully associative key/value cache with lru replacement
// built from a chain of lkvc_cell entries; uses lkvc_pkg
//
//  channel | signals                          | direction | accept
//  --------+----------------------------------+-----------+------------------------
//  in      | in_valid in_ready func key value | sink      | in_valid & in_ready
//  out     | out_valid out_ready hit          | source    | out_valid & out_ready
//          | read_value evicted               |           |
//  cfg     | cfg_wr_en cfg_wr_data            | sink      | cfg_wr_en
//
// one operation per cycle unless stalled; its result is out in the next cycle.
// the cycle is set by the parallel key compare over all cells and the one-step
// shift of the chain that moves the touched or new entry to the head.
// cell 0 is the most recent entry, valid entries fill cells 0..count-1.
// reset clears every cell's valid bit at once; no clearing pass is needed.
// the output register holds one result; input is taken while it is empty or drained.

module lru_key_value_cache_top #(
    parameter int ENTRIES     = 16,
    parameter int KEY_WIDTH   = 16,
    parameter int VALUE_WIDTH = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           func,
    input  logic [KEY_WIDTH-1:0]           key,
    input  logic [VALUE_WIDTH-1:0]         value,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic                           hit,
    output logic [VALUE_WIDTH-1:0]         read_value,
    output logic                           evicted,
    input  logic                           cfg_wr_en,
    input  logic [lkvc_pkg::CAP_WIDTH-1:0] cfg_wr_data
);

    import lkvc_pkg::*;

    localparam int IW   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW   = $clog2(ENTRIES + 1);
    localparam int CMPW = (CW > CAP_WIDTH) ? CW : CAP_WIDTH;

    // cell array signals
    logic [ENTRIES-1:0]                  cell_valid;
    logic [ENTRIES-1:0][KEY_WIDTH-1:0]   cell_key;
    logic [ENTRIES-1:0][VALUE_WIDTH-1:0] cell_value;
    logic [ENTRIES-1:0]                  cell_match;
    logic [ENTRIES-1:0]                  cell_shift;

    // control registers
    logic                 cap_default_reg;
    logic [CAP_WIDTH-1:0] cap_reg;
    logic [CW-1:0]        count_reg;
    logic [CW-1:0]        count_next;

    // output registers
    logic                   out_valid_reg;
    logic                   hit_reg;
    logic [VALUE_WIDTH-1:0] read_value_reg;
    logic                   evicted_reg;

    logic                   accept;
    logic                   hit_any;
    logic [IW-1:0]          hit_pos;
    logic [VALUE_WIDTH-1:0] hit_value;
    logic [CMPW-1:0]        eff_cap;
    logic                   full;
    logic                   do_evict;
    logic                   update;
    logic [CW-1:0]          limit;
    logic [VALUE_WIDTH-1:0] head_value;

    assign accept   = in_valid && in_ready;
    assign in_ready = !out_valid_reg || out_ready;

    // capacity register; the reset default means the full entry count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_default_reg <= 1'b1;
            cap_reg         <= '0;
        end
        else if (cfg_wr_en)
        begin
            cap_default_reg <= 1'b0;
            cap_reg         <= cfg_wr_data;
        end
    end

    // effective capacity, clamped to 1..ENTRIES
    always_comb
    begin
        if (cap_default_reg)
        begin
            eff_cap = CMPW'(ENTRIES);
        end
        else if (cap_reg == '0)
        begin
            eff_cap = CMPW'(1);
        end
        else if (CMPW'(cap_reg) > CMPW'(ENTRIES))
        begin
            eff_cap = CMPW'(ENTRIES);
        end
        else
        begin
            eff_cap = CMPW'(cap_reg);
        end
    end

    assign full = (count_reg != '0) && (CMPW'(count_reg) >= eff_cap);

    // hit position and stored value, keys are unique among valid cells
    always_comb
    begin
        hit_pos   = '0;
        hit_value = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (cell_match[i])
            begin
                hit_pos = IW'(i);
            end
            hit_value = hit_value | (cell_match[i] ? cell_value[i] : '0);
        end
    end

    assign hit_any  = |cell_match;
    assign do_evict = (func == FUNC_SET) && !hit_any && full;
    assign update   = accept && (hit_any || (func == FUNC_SET));

    // deepest cell that moves: the hit cell, or the tail on insert
    always_comb
    begin
        if (hit_any)
        begin
            limit = CW'(hit_pos);
        end
        else if (full)
        begin
            limit = count_reg - CW'(1);
        end
        else
        begin
            limit = count_reg;
        end
    end

    assign head_value = (func == FUNC_SET) ? value : hit_value;

    // entry chain, cell 0 takes the head entry
    for (genvar g = 0; g < ENTRIES; g++)
    begin : g_cell
        assign cell_shift[g] = update && (CW'(g) <= limit);

        if (g == 0)
        begin : g_head
            lkvc_cell #(
                .KEY_WIDTH   (KEY_WIDTH),
                .VALUE_WIDTH (VALUE_WIDTH)
            ) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .shift_en   (cell_shift[g]),
                .prev_valid (1'b1),
                .prev_key   (key),
                .prev_value (head_value),
                .lookup_key (key),
                .valid      (cell_valid[g]),
                .key        (cell_key[g]),
                .value      (cell_value[g]),
                .match      (cell_match[g])
            );
        end
        else
        begin : g_body
            lkvc_cell #(
                .KEY_WIDTH   (KEY_WIDTH),
                .VALUE_WIDTH (VALUE_WIDTH)
            ) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .shift_en   (cell_shift[g]),
                .prev_valid (cell_valid[g-1]),
                .prev_key   (cell_key[g-1]),
                .prev_value (cell_value[g-1]),
                .lookup_key (key),
                .valid      (cell_valid[g]),
                .key        (cell_key[g]),
                .value      (cell_value[g]),
                .match      (cell_match[g])
            );
        end
    end

    // held entry count
    always_comb
    begin
        count_next = count_reg;
        if (accept && (func == FUNC_SET) && !hit_any && !full)
        begin
            count_next = count_reg + CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // result beat register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            out_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hit_reg        <= hit_any;
            read_value_reg <= (hit_any && (func == FUNC_GET)) ? hit_value : '0;
            evicted_reg    <= do_evict;
        end
    end

    assign out_valid  = out_valid_reg;
    assign hit        = hit_reg;
    assign read_value = read_value_reg;
    assign evicted    = evicted_reg;

endmodule : lru_key_value_cache_top

[src/lkvc_checker.sv]
// lkvc_checker: port-level assertions for lru_key_value_cache_top
// bound to the top level below; uses lkvc_pkg for the config width

module lkvc_checker #(
    parameter int VALUE_WIDTH = 16
) (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_valid,
    input logic                           in_ready,
    input logic                           func,
    input logic                           out_valid,
    input logic                           out_ready,
    input logic                           hit,
    input logic [VALUE_WIDTH-1:0]         read_value,
    input logic                           evicted,
    input logic                           cfg_wr_en,
    input logic [lkvc_pkg::CAP_WIDTH-1:0] cfg_wr_data
);

    import lkvc_pkg::*;

    // stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(hit) && $stable(read_value)
            && $stable(evicted))
        else $error("result beat changed while stalled");

    // single result slot: no input beat while a result is stalled
    a_one_deep: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("input taken while result stalled");

    // every input beat gives a result beat on the next cycle
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> out_valid)
        else $error("missing result beat");

    // a hit never evicts, and a miss reads zero
    a_hit_evict: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(hit && evicted) && (hit || read_value == '0))
        else $error("inconsistent result fields");

    // a get can never evict
    a_get_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (func == FUNC_GET) |=> !evicted)
        else $error("eviction on a get");

endmodule : lkvc_checker

bind lru_key_value_cache_top lkvc_checker #(
    .VALUE_WIDTH (VALUE_WIDTH)
) u_lkvc_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .func        (func),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .hit         (hit),
    .read_value  (read_value),
    .evicted     (evicted),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
);
